/* src/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants for the bitmap frame allocator
// Bitmap geometry, command and status codes, controller states and the
// command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int WORD_W    = 32;
  localparam int WORD_CNT  = 128;
  localparam int IDX_W     = 7;
  localparam int BIT_W     = 5;
  localparam int FRAME_W   = 12;
  localparam int COUNT_W   = 13;
  localparam logic [COUNT_W-1:0] CAPACITY    = 13'd4096;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [1:0] {
    CMD_FIND  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_TEST  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NONE_FREE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_APPLY,
    S_SCAN
  } state_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_FRAME,
    RD_FIRST,
    RD_NEXT
  } rd_sel_t;

  typedef enum logic [1:0] {
    RES_RANGE,
    RES_NONE,
    RES_FOUND,
    RES_OP
  } res_sel_t;

  typedef struct packed {
    logic     load_req;
    rd_sel_t  rd_sel;
    logic     write_word;
    logic     load_result;
    res_sel_t res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic range_bad;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } ctrl_stat_t;

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

/* src/bfa_if.sv */
// ----------------------------------------------------------------------------
// bfa_if: channel interfaces of the bitmap frame allocator
// Request, response and configuration channels, each valid/ready.
// ----------------------------------------------------------------------------
interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] frame_number;

  modport source (output valid, output cmd, output frame_number, input ready);
  modport sink (input valid, input cmd, input frame_number, output ready);
endinterface

interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] found_frame;
  logic        in_use;
  logic [12:0] used_count;

  modport source (output valid, output status, output found_frame, output in_use,
                  output used_count, input ready);
  modport sink (input valid, input status, input found_frame, input in_use,
                input used_count, output ready);
endinterface

interface bfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] max_frames;

  modport source (output valid, output max_frames, input ready);
  modport sink (input valid, input max_frames, output ready);
endinterface

/* src/bfa_datapath.sv */
// ----------------------------------------------------------------------------
// bfa_datapath: bitmap memory, frame counter and result register
// Holds the frame bitmap with per-word valid bits, the limit register, the
// captured request, the word scan logic and the response register.
// ----------------------------------------------------------------------------
module bfa_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [1:0]                          req_cmd,
  input  logic [bfa_pkg::FRAME_W-1:0]         req_frame,
  input  logic                                cfg_valid,
  input  logic [bfa_pkg::COUNT_W-1:0]         cfg_max_frames,
  input  bfa_pkg::ctrl_cmd_t                  ctl,
  output bfa_pkg::ctrl_stat_t                 stat,
  input  logic                                rsp_ready,
  output logic                                rsp_valid,
  output logic [1:0]                          rsp_status,
  output logic [bfa_pkg::FRAME_W-1:0]         rsp_found,
  output logic                                rsp_in_use,
  output logic [bfa_pkg::COUNT_W-1:0]         rsp_used
);

  logic [bfa_pkg::COUNT_W-1:0] max_frames;
  logic [bfa_pkg::COUNT_W-1:0] frames_used;
  logic [bfa_pkg::COUNT_W-1:0] frames_used_next;
  bfa_pkg::cmd_t               cmd;
  logic [bfa_pkg::FRAME_W-1:0] frame;
  logic [bfa_pkg::IDX_W-1:0]   scan_idx;

  logic [bfa_pkg::WORD_W-1:0]   mem [bfa_pkg::WORD_CNT];
  logic [bfa_pkg::WORD_CNT-1:0] word_valid;
  logic [bfa_pkg::WORD_W-1:0]   rdata;

  logic                        out_valid;
  bfa_pkg::status_t            out_status;
  logic [bfa_pkg::FRAME_W-1:0] out_found;
  logic                        out_in_use;
  logic [bfa_pkg::COUNT_W-1:0] out_used;

  logic [bfa_pkg::COUNT_W-1:0] limit;
  logic [bfa_pkg::COUNT_W-1:0] base;
  logic [bfa_pkg::COUNT_W-1:0] next_base;
  logic [bfa_pkg::COUNT_W-1:0] span;
  logic [bfa_pkg::WORD_W-1:0]  scan_mask;
  logic [bfa_pkg::WORD_W-1:0]  free_bits;
  logic [bfa_pkg::BIT_W-1:0]   hit_pos;
  logic [bfa_pkg::WORD_W-1:0]  bit_mask;
  logic [bfa_pkg::WORD_W-1:0]  wdata;
  logic                        rd_en;
  logic [bfa_pkg::IDX_W-1:0]   rd_addr;
  logic [bfa_pkg::IDX_W-1:0]   wr_addr;
  logic                        wr_en;

  assign limit     = (max_frames > bfa_pkg::CAPACITY) ? bfa_pkg::CAPACITY : max_frames;
  assign base      = {1'b0, scan_idx, {bfa_pkg::BIT_W{1'b0}}};
  assign next_base = {({1'b0, scan_idx} + 8'd1), {bfa_pkg::BIT_W{1'b0}}};
  assign span      = limit - base;

  always_comb begin
    if (limit <= base) begin
      scan_mask = '0;
    end else if (span >= bfa_pkg::COUNT_W'(bfa_pkg::WORD_W)) begin
      scan_mask = '1;
    end else begin
      scan_mask = (bfa_pkg::WORD_W'(1) << span[bfa_pkg::BIT_W-1:0]) - bfa_pkg::WORD_W'(1);
    end
  end

  assign free_bits = ~rdata & scan_mask;
  assign hit_pos   = bfa_pkg::lowest_set(free_bits);
  assign bit_mask  = bfa_pkg::WORD_W'(1) << frame[bfa_pkg::BIT_W-1:0];
  assign wr_addr   = frame[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
  assign wdata     = (cmd == bfa_pkg::CMD_ALLOC) ? (rdata | bit_mask) : (rdata & ~bit_mask);
  assign wr_en     = ctl.write_word;

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    unique case (ctl.rd_sel)
      bfa_pkg::RD_NONE:  rd_en = 1'b0;
      bfa_pkg::RD_FRAME: rd_addr = wr_addr;
      bfa_pkg::RD_FIRST: rd_addr = '0;
      bfa_pkg::RD_NEXT:  rd_addr = scan_idx + bfa_pkg::IDX_W'(1);
    endcase
  end

  always_comb begin
    frames_used_next = frames_used;
    if (ctl.write_word) begin
      if (cmd == bfa_pkg::CMD_ALLOC && frames_used < bfa_pkg::CAPACITY) begin
        frames_used_next = frames_used + bfa_pkg::COUNT_W'(1);
      end else if (cmd == bfa_pkg::CMD_FREE && frames_used != '0) begin
        frames_used_next = frames_used - bfa_pkg::COUNT_W'(1);
      end
    end
  end

  assign stat.cmd       = cmd;
  assign stat.range_bad = {1'b0, frame} >= limit;
  assign stat.scan_hit  = |free_bits;
  assign stat.scan_last = next_base >= limit;
  assign stat.out_free  = !out_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= word_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid  <= '0;
      frames_used <= '0;
      max_frames  <= bfa_pkg::LIMIT_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        word_valid[wr_addr] <= 1'b1;
      end
      frames_used <= frames_used_next;
      if (cfg_valid) begin
        max_frames <= cfg_max_frames;
      end
      if (ctl.load_result) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      cmd   <= bfa_pkg::cmd_t'(req_cmd);
      frame <= req_frame;
    end
    unique case (ctl.rd_sel)
      bfa_pkg::RD_FIRST: scan_idx <= '0;
      bfa_pkg::RD_NEXT:  scan_idx <= scan_idx + bfa_pkg::IDX_W'(1);
      default:           scan_idx <= scan_idx;
    endcase
    if (ctl.load_result) begin
      out_found  <= '0;
      out_in_use <= 1'b0;
      out_used   <= frames_used_next;
      unique case (ctl.res_sel)
        bfa_pkg::RES_RANGE: out_status <= bfa_pkg::ST_RANGE;
        bfa_pkg::RES_NONE:  out_status <= bfa_pkg::ST_NONE_FREE;
        bfa_pkg::RES_FOUND: begin
          out_status <= bfa_pkg::ST_OK;
          out_found  <= {scan_idx, hit_pos};
        end
        bfa_pkg::RES_OP: begin
          out_status <= bfa_pkg::ST_OK;
          out_in_use <= (cmd == bfa_pkg::CMD_TEST) && |(rdata & bit_mask);
        end
      endcase
    end
  end

  assign rsp_valid  = out_valid;
  assign rsp_status = out_status;
  assign rsp_found  = out_found;
  assign rsp_in_use = out_in_use;
  assign rsp_used   = out_used;

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (frames_used == $past(frames_used)) ||
    (frames_used == $past(frames_used) + bfa_pkg::COUNT_W'(1)) ||
    (frames_used == $past(frames_used) - bfa_pkg::COUNT_W'(1)))
    else $error("frame count moved by more than one");

endmodule

/* src/bfa_controller.sv */
// ----------------------------------------------------------------------------
// bfa_controller: request sequencer of the bitmap frame allocator
// Accepts a request, steps the datapath through the range check, the word
// read and update, or the word-by-word free frame search, then loads a result.
// ----------------------------------------------------------------------------
module bfa_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  bfa_pkg::ctrl_stat_t stat,
  output bfa_pkg::ctrl_cmd_t  ctl
);

  bfa_pkg::state_t state;
  bfa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    req_ready       = 1'b0;
    ctl.load_req    = 1'b0;
    ctl.rd_sel      = bfa_pkg::RD_NONE;
    ctl.write_word  = 1'b0;
    ctl.load_result = 1'b0;
    ctl.res_sel     = bfa_pkg::RES_OP;
    unique case (state)
      bfa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.load_req = 1'b1;
          state_next   = bfa_pkg::S_CHECK;
        end
      end
      bfa_pkg::S_CHECK: begin
        priority if (stat.cmd == bfa_pkg::CMD_FIND) begin
          ctl.rd_sel = bfa_pkg::RD_FIRST;
          state_next = bfa_pkg::S_SCAN;
        end else if (stat.range_bad) begin
          if (stat.out_free) begin
            ctl.load_result = 1'b1;
            ctl.res_sel     = bfa_pkg::RES_RANGE;
            state_next      = bfa_pkg::S_IDLE;
          end
        end else begin
          ctl.rd_sel = bfa_pkg::RD_FRAME;
          state_next = bfa_pkg::S_APPLY;
        end
      end
      bfa_pkg::S_APPLY: begin
        if (stat.out_free) begin
          ctl.write_word  = (stat.cmd == bfa_pkg::CMD_ALLOC) ||
                            (stat.cmd == bfa_pkg::CMD_FREE);
          ctl.load_result = 1'b1;
          ctl.res_sel     = bfa_pkg::RES_OP;
          state_next      = bfa_pkg::S_IDLE;
        end
      end
      bfa_pkg::S_SCAN: begin
        priority if (stat.scan_hit || stat.scan_last) begin
          if (stat.out_free) begin
            ctl.load_result = 1'b1;
            ctl.res_sel     = stat.scan_hit ? bfa_pkg::RES_FOUND : bfa_pkg::RES_NONE;
            state_next      = bfa_pkg::S_IDLE;
          end
        end else begin
          ctl.rd_sel = bfa_pkg::RD_NEXT;
        end
      end
      default: state_next = bfa_pkg::S_IDLE;
    endcase
  end

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load_result |-> stat.out_free)
    else $error("result loaded while response register still held");

  a_write_only_update: assert property (@(posedge clk) disable iff (rst)
    ctl.write_word |-> (stat.cmd == bfa_pkg::CMD_ALLOC || stat.cmd == bfa_pkg::CMD_FREE))
    else $error("bitmap written by a find or test request");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == bfa_pkg::S_CHECK))
    else $error("accepted request did not enter range check");

  a_write_ends_request: assert property (@(posedge clk) disable iff (rst)
    ctl.write_word |-> ctl.load_result)
    else $error("bitmap written without a result");

endmodule

/* src/bitmap_frame_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_frame_allocator: bitmap physical frame allocator
// Usage:
//   req carries cmd (find, allocate, free, test) and frame_number; each
//   request gives exactly one item on rsp with status, found_frame, in_use
//   and used_count. cfg writes max_frames and is always ready; the user
//   must write it only while no request is outstanding, which the block
//   does not enforce. Allocate, free and test do the range check with the
//   word read, then the update. Out of range answers from the range check.
//   Find reads one 32-bit bitmap word per cycle from the bitmap memory,
//   1 to 128 words, until one holds a free frame or the limit is reached.
//   One request is in flight at a time; a new request is taken while the
//   previous response still waits in the output register.
//   Reset clears the bitmap through per-word valid bits, zeroes the frame
//   count and sets max_frames to 4096; no clearing pass is needed.
//   When rsp is stalled, the finished request holds in its final step until
//   the output register frees, and no state is updated before then.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator (
  input  logic    clk,
  input  logic    rst,
  bfa_req_if.sink req,
  bfa_rsp_if.source rsp,
  bfa_cfg_if.sink cfg
);

  bfa_pkg::ctrl_cmd_t  ctl;
  bfa_pkg::ctrl_stat_t stat;

  assign cfg.ready = 1'b1;

  bfa_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  bfa_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_cmd        (req.cmd),
    .req_frame      (req.frame_number),
    .cfg_valid      (cfg.valid),
    .cfg_max_frames (cfg.max_frames),
    .ctl            (ctl),
    .stat           (stat),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_status     (rsp.status),
    .rsp_found      (rsp.found_frame),
    .rsp_in_use     (rsp.in_use),
    .rsp_used       (rsp.used_count)
  );

endmodule
